>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/abst_pkg.sv
// ---------------------------------------------------------------------------
// abst_pkg
// Shared constants and types for the array binary search tree.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package abst_pkg;

  localparam int LEVELS  = 10;
  localparam int KEY_W   = 32;
  localparam int LVL_W   = $clog2(LEVELS + 1);
  localparam int HGT_W   = 4;
  localparam int HGT_MAX = 15;
  localparam int CLR_W   = LEVELS - 1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK
  } state_t;

  // walk word handed from level to level
  typedef struct packed {
    logic              vld;
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [LEVELS-1:0] pos;
    logic [LVL_W-1:0]  lvl;
  } tok_t;

  // walk ends in this level
  typedef struct packed {
    logic             vld;
    logic             found;
    logic             wr;
    logic [LVL_W-1:0] lvl;
  } fin_t;

endpackage

>>> rtl/array_bst_insert_search.sv
// ---------------------------------------------------------------------------
// array_bst_insert_search
// Binary search tree in an implicitly indexed table, one cell per level.
// ---------------------------------------------------------------------------
//  channel   | handshake          | fields
//  ----------+--------------------+---------------------------
//  command   | start / busy       | opcode, key
//  result    | done (strobe)      | found, full_res, height
//
// A word walks one level per cycle, each level a cell with its own RAM.
// The result strobe is registered from the level where the walk ends;
// a new word may be taken in the cycle the strobe is shown.
// After reset every table slot is cleared to zero, busy held high.
// The receiver cannot stall; done is a one-cycle strobe.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module array_bst_insert_search (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        opcode,
  input  logic signed [abst_pkg::KEY_W-1:0] key,
  output logic                        done,
  output logic                        found,
  output logic                        full_res,
  output logic [abst_pkg::HGT_W-1:0]  height
);

  import abst_pkg::*;

  state_t state;
  state_t state_next;

  logic [CLR_W-1:0] clr_cnt;
  logic             clearing;
  logic             accept;

  tok_t tin  [LEVELS];
  tok_t cur  [LEVELS];
  tok_t tout [LEVELS];
  fin_t fin  [LEVELS];
  logic [KEY_W-1:0] rdata [LEVELS];

  logic [LEVELS-1:0] fin_vld;
  logic [LEVELS-1:0] tok_vld;

  logic             walk_end;
  logic             hit;
  logic             off_end;
  logic             wr_any;
  logic [LVL_W-1:0] wr_lvl;
  logic [LVL_W-1:0] hgt;
  logic [LVL_W-1:0] hgt_next;

  assign accept = start && !busy;

  always_comb begin
    tin[0].vld = accept;
    tin[0].op  = opcode;
    tin[0].key = key;
    tin[0].pos = LEVELS'(1);
    tin[0].lvl = LVL_W'(1);
  end

  genvar gi;
  generate
    for (gi = 0; gi < LEVELS; gi++) begin : g_lvl
      localparam int AW = (gi == 0) ? 1 : gi;

      if (gi > 0) begin : g_link
        assign tin[gi] = tout[gi-1];
      end

      abst_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .tin   (tin[gi]),
        .rdata (rdata[gi]),
        .cur   (cur[gi]),
        .tout  (tout[gi]),
        .fin   (fin[gi])
      );

      abst_ram #(
        .AW (AW),
        .DW (KEY_W)
      ) u_ram (
        .clk   (clk),
        .we    (clearing || fin[gi].wr),
        .waddr (clearing ? clr_cnt[AW-1:0] : cur[gi].pos[AW-1:0]),
        .wdata (clearing ? '0 : cur[gi].key),
        .raddr (tin[gi].pos[AW-1:0]),
        .rdata (rdata[gi])
      );

      assign fin_vld[gi] = fin[gi].vld;
      assign tok_vld[gi] = cur[gi].vld;
    end
  endgenerate

  always_comb begin
    hit    = 1'b0;
    wr_any = 1'b0;
    wr_lvl = '0;
    for (int i = 0; i < LEVELS; i++) begin
      hit    = hit | fin[i].found;
      wr_any = wr_any | fin[i].wr;
      wr_lvl = wr_lvl | (fin[i].wr ? fin[i].lvl : '0);
    end
  end

  assign off_end  = tout[LEVELS-1].vld;
  assign walk_end = (|fin_vld) || off_end;

  always_comb begin
    hgt_next = hgt;
    if (wr_any && (wr_lvl > hgt)) begin
      hgt_next = wr_lvl;
    end
  end

  // state machine
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    unique case (state)
      S_CLEAR: begin
        busy     = 1'b1;
        clearing = 1'b1;
      end
      S_IDLE: begin
        busy     = 1'b0;
        clearing = 1'b0;
      end
      S_WALK: begin
        busy     = 1'b1;
        clearing = 1'b0;
      end
      default: begin
        busy     = 1'b1;
        clearing = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      hgt     <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
      hgt  <= hgt_next;
      done <= walk_end;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_end) begin
      found    <= hit;
      full_res <= off_end && (tout[LEVELS-1].op == OP_INSERT) &&
                  (tout[LEVELS-1].key != '0);
      height   <= (int'(hgt_next) > HGT_MAX) ? HGT_W'(HGT_MAX) : HGT_W'(hgt_next);
    end
  end

  `ASSERT_ALWAYS(a_single_end, clk, rst, $onehot0({off_end, fin_vld}), "walk ends twice")
  `ASSERT_ALWAYS(a_single_tok, clk, rst, $onehot0(tok_vld), "two words in flight")
  `ASSERT_IMPLY(a_clear_quiet, clk, rst, clearing, !(|tok_vld), "walk during clear")
  `ASSERT_NEXT(a_strobe_gap, clk, rst, done, !done, "back to back results")
  `ASSERT_ALWAYS(a_height_mono, clk, rst, hgt >= $past(hgt), "height dropped")

endmodule

>>> rtl/abst_ram.sv
// ---------------------------------------------------------------------------
// abst_ram
// Single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module abst_ram #(
  parameter int AW = 1,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/abst_cell.sv
// ---------------------------------------------------------------------------
// abst_cell
// One tree level: compares the walk word with the slot read for it and
// either ends the walk here or steers it to the child in the next level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module abst_cell (
  input  logic                clk,
  input  logic                rst,
  input  abst_pkg::tok_t      tin,
  input  logic [abst_pkg::KEY_W-1:0] rdata,
  output abst_pkg::tok_t      cur,
  output abst_pkg::tok_t      tout,
  output abst_pkg::fin_t      fin
);

  import abst_pkg::*;

  logic empty;
  logic eq;
  logic gt;
  logic ins_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.vld <= 1'b0;
    end else begin
      cur.vld <= tin.vld;
    end
    cur.op  <= tin.op;
    cur.key <= tin.key;
    cur.pos <= tin.pos;
    cur.lvl <= tin.lvl;
  end

  assign empty  = (rdata == '0);
  assign eq     = (rdata == cur.key);
  assign gt     = ($signed(cur.key) > $signed(rdata));
  assign ins_ok = (cur.op == OP_INSERT) && (cur.key != '0);

  always_comb begin
    fin.vld   = cur.vld && (empty || eq);
    fin.found = cur.vld && !empty && eq;
    fin.wr    = cur.vld && empty && ins_ok;
    fin.lvl   = cur.lvl;

    tout.vld = cur.vld && !empty && !eq;
    tout.op  = cur.op;
    tout.key = cur.key;
    tout.pos = {cur.pos[LEVELS-2:0], gt};
    tout.lvl = cur.lvl + LVL_W'(1);
  end

endmodule
